// ===== sv/kcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_pkg
// types and constants shared by the keypad code lock modules
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int CODE_LEN = 11;
  localparam int KEY_W    = 8;
  localparam int CODE_W   = CODE_LEN * KEY_W;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [3:0]       count_t;
  typedef logic [3:0]       attempts_t;
  typedef logic [1:0]       cfg_index_t;

  localparam key_t   KEY_NONE   = 8'h00;
  localparam key_t   KEY_HASH   = 8'h23;
  localparam count_t COUNT_FULL = 4'd11;
  localparam count_t COUNT_OVER = 4'd12;

  // register indexes of the configuration port
  localparam cfg_index_t REG_CODE_FIRST_EIGHT = 2'd0;
  localparam cfg_index_t REG_CODE_LAST_THREE  = 2'd1;
  localparam cfg_index_t REG_ATTEMPT_BUDGET   = 2'd2;

  localparam logic [63:0] CODE_FIRST_EIGHT_RESET = 64'h4143_4142_4144_4131;
  localparam logic [23:0] CODE_LAST_THREE_RESET  = 24'h33_3739;
  localparam attempts_t   ATTEMPT_BUDGET_RESET   = 4'd3;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_START  = 3'd1,
    EV_CHAR   = 3'd2,
    EV_SHORT  = 3'd3,
    EV_OK     = 3'd4,
    EV_WRONG  = 3'd5,
    EV_LOCKED = 3'd6,
    EV_LONG   = 3'd7
  } event_t;

  // what the front saw in one scan sample
  typedef enum logic [1:0] {
    TOK_NONE = 2'd0,
    TOK_HASH = 2'd1,
    TOK_CHAR = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    key_t      key;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== sv/kcl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_front
// accepts scan samples and turns them into key release tokens
// ----------------------------------------------------------------------------
module kcl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  kcl_pkg::key_t         key_code,
  input  kcl_pkg::queue_status_t q_status,
  output logic                  push,
  output kcl_pkg::token_t       push_tok
);
  import kcl_pkg::*;

  key_t previous_key;

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  // a key counts on release, the released key is the previous sample
  always_comb begin
    push_tok.key  = previous_key;
    push_tok.kind = TOK_NONE;
    if (key_code == KEY_NONE && previous_key != KEY_NONE) begin
      push_tok.kind = (previous_key == KEY_HASH) ? TOK_HASH : TOK_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_key <= KEY_NONE;
    end else if (push) begin
      previous_key <= key_code;
    end
  end

endmodule

// ===== sv/kcl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_queue
// short token queue between front and back
// ----------------------------------------------------------------------------
module kcl_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  kcl_pkg::token_t        push_tok,
  input  logic                   pop,
  output kcl_pkg::token_t        head_tok,
  output kcl_pkg::queue_status_t status
);
  import kcl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   level;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (level == CNT_W'(DEPTH));
  assign status.empty = (level == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_tok     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== sv/kcl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcl_back
// lock state, entry buffer, code compare and result register
// ----------------------------------------------------------------------------
module kcl_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  kcl_pkg::cfg_index_t    cfg_index,
  input  logic [63:0]            cfg_data,
  input  kcl_pkg::token_t        tok,
  input  logic                   tok_valid,
  output logic                   tok_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output kcl_pkg::event_t        out_event,
  output kcl_pkg::attempts_t     out_attempts,
  output logic                   out_entering
);
  import kcl_pkg::*;

  logic [63:0]   code_first_eight;
  logic [23:0]   code_last_three;
  attempts_t     attempt_budget;

  logic          mode_entering;
  count_t        char_count;
  attempts_t     attempts_remaining;
  key_t          entry_buffer [CODE_LEN];

  logic          mode_next;
  count_t        count_next;
  attempts_t     attempts_next;
  event_t        event_next;
  logic          store_char;
  logic          code_match;
  logic          take;
  logic [CODE_W-1:0] code_all;

  assign tok_ready = !out_valid || out_ready;
  assign take      = tok_valid && tok_ready;
  assign code_all  = {code_first_eight, code_last_three};

  // first character sits in the top byte
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (entry_buffer[i] != code_all[CODE_W-1-KEY_W*i -: KEY_W]) begin
        code_match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_next     = mode_entering;
    count_next    = char_count;
    attempts_next = attempts_remaining;
    event_next    = EV_NONE;
    store_char    = 1'b0;
    case (tok.kind)
      TOK_HASH: begin
        if (!mode_entering) begin
          mode_next  = 1'b1;
          event_next = EV_START;
        end else if (char_count < COUNT_FULL) begin
          count_next = '0;
          event_next = EV_SHORT;
        end else if (char_count > COUNT_FULL) begin
          count_next = '0;
          event_next = EV_LONG;
        end else if (code_match) begin
          count_next    = '0;
          mode_next     = 1'b0;
          attempts_next = attempt_budget;
          event_next    = EV_OK;
        end else if (attempts_remaining <= 4'd1) begin
          count_next    = '0;
          mode_next     = 1'b0;
          attempts_next = attempt_budget;
          event_next    = EV_LOCKED;
        end else begin
          count_next    = '0;
          attempts_next = attempts_remaining - 1'b1;
          event_next    = EV_WRONG;
        end
      end
      TOK_CHAR: begin
        if (mode_entering) begin
          store_char = (char_count < COUNT_FULL);
          if (char_count < COUNT_OVER) begin
            count_next = char_count + 1'b1;
          end
          event_next = EV_CHAR;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_first_eight <= CODE_FIRST_EIGHT_RESET;
      code_last_three  <= CODE_LAST_THREE_RESET;
      attempt_budget   <= ATTEMPT_BUDGET_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CODE_FIRST_EIGHT: code_first_eight <= cfg_data;
        REG_CODE_LAST_THREE:  code_last_three  <= cfg_data[23:0];
        REG_ATTEMPT_BUDGET:   attempt_budget   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && store_char) begin
      entry_buffer[char_count] <= tok.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_entering      <= 1'b0;
      char_count         <= '0;
      attempts_remaining <= ATTEMPT_BUDGET_RESET;
      out_valid          <= 1'b0;
    end else begin
      if (take) begin
        mode_entering      <= mode_next;
        char_count         <= count_next;
        attempts_remaining <= attempts_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_event    <= event_next;
      out_attempts <= attempts_next;
      out_entering <= mode_next;
    end
  end

endmodule

// ===== sv/keypad_code_lock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_code_lock
// keypad combination lock fed by one keypad scan sample per beat
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tdata[7:0] key_code (0 when no key held)
//  m_axis    out        tdata[2:0] event_res, [6:3] attempts_left, [7] entering
//  cfg       in         write enable, index 0..2, 64-bit data, no read-back
//
//  one beat per cycle sustained while m_tready stays high, every input beat gives exactly one result beat
//  an accepted sample is written into a queue slot, then from the back into the result register
//  the back updates lock state and result on the same clock edge
//  rst is synchronous, active high; it reloads the code, budget and lock state
//  a stalled m_axis fills the queue and only then drops s_tready
// ----------------------------------------------------------------------------
module keypad_code_lock #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  // scan samples
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] key_code
  // results
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [2:0] event_res, [6:3] attempts_left, [7] entering
  // configuration writes
  input  logic                cfg_wr_en,
  input  kcl_pkg::cfg_index_t cfg_index,
  input  logic [63:0]         cfg_data
);
  import kcl_pkg::*;

  token_t        push_tok;
  token_t        head_tok;
  logic          push;
  logic          pop;
  queue_status_t q_status;
  event_t        out_event;
  attempts_t     out_attempts;
  logic          out_entering;

  // front: release detection, one token per accepted sample
  kcl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .key_code (s_tdata),
    .q_status (q_status),
    .push     (push),
    .push_tok (push_tok)
  );

  // tokens wait here while the result side stalls
  kcl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .status   (q_status)
  );

  // back: entry state, compare and result register
  kcl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tok          (head_tok),
    .tok_valid    (!q_status.empty),
    .tok_ready    (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_event    (out_event),
    .out_attempts (out_attempts),
    .out_entering (out_entering)
  );

  assign m_tdata = {out_entering, out_attempts, out_event};

  // result register is empty right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // queue cannot be full and empty at once
  assert property (@(posedge clk) disable iff (rst) !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

  // entry start always leaves the lock entering
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_event == EV_START) |-> out_entering)
    else $error("entry start without entering");

  // events that only occur during entry keep entering set
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_event == EV_CHAR || out_event == EV_SHORT ||
                  out_event == EV_LONG || out_event == EV_WRONG)) |-> out_entering)
    else $error("entry event reported while idle");

  // correct code and lockout both return to idle
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_event == EV_OK || out_event == EV_LOCKED)) |-> !out_entering)
    else $error("lock still entering after entry closed");

endmodule
